### hdl/bsd_pkg.sv
package bsd_pkg;

  // Genes per cell above this are clamped
  localparam int unsigned MAX_GENES = 262144;
  localparam logic [18:0] MAX_GENES_W = 19'(MAX_GENES);

  // Result kinds
  localparam logic [1:0] KIND_GENE  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_GENE_COUNT = 2'd0;
  localparam logic [1:0] CFG_VALUE_MODE = 2'd1;
  localparam logic [1:0] CFG_CELL_COUNT = 2'd2;

  typedef enum logic [1:0] {
    PH_BITMAP = 2'd0,
    PH_VALUES = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [18:0] gene_count;
    logic        value_mode;
    logic [23:0] cell_count;
  } bsd_cfg_t;

  // All results caused by one input item
  typedef struct packed {
    logic [7:0]  mask;      // set bitmap bits still to emit
    logic [14:0] base;      // bitmap byte number
    logic        has_val;
    logic [31:0] val;
    logic        has_end;
    logic [31:0] total;
    logic        done;
    logic [23:0] cell_no;
  } bsd_rec_t;

endpackage

### hdl/bsd_parser.sv
module bsd_parser
  import bsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  logic [7:0] stream_byte,
  input  bsd_cfg_t  cfg,
  output bsd_rec_t  rec,
  output logic      rec_any
);

  phase_t      phase_r, phase_nxt;
  logic [14:0] bbs_r, bbs_nxt;
  logic [18:0] exp_r, exp_nxt;
  logic [18:0] vrem_r, vrem_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [23:0] cell_r, cell_nxt;
  logic [31:0] cum_r, cum_nxt;

  logic [18:0] g_clamp;
  logic [18:0] g_round;
  logic [15:0] bm_len;
  logic [3:0]  popc;
  logic [18:0] exp_add;
  logic [23:0] cell_lim;
  logic        finish;
  logic [18:0] fin_exp;
  logic [32:0] sum;
  logic [31:0] tot_sat;
  logic        is_last;
  logic [18:0] vrem_dec;

  // Bitmap length in bytes
  always_comb begin
    g_clamp = cfg.gene_count;
    if (g_clamp == 19'd0) g_clamp = 19'd1;
    if (g_clamp > MAX_GENES_W) g_clamp = MAX_GENES_W;
    g_round = g_clamp + 19'd7;
    bm_len  = g_round[18:3];
  end

  always_comb begin
    popc = 4'd0;
    for (int k = 0; k < 8; k++) popc = popc + {3'd0, stream_byte[k]};
  end

  assign exp_add  = exp_r + {15'd0, popc};
  assign cell_lim = (cfg.cell_count == 24'd0) ? 24'd1 : cfg.cell_count;
  assign sum      = {1'b0, cum_r} + {14'd0, fin_exp};
  assign tot_sat  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign is_last  = ({1'b0, cell_r} + 25'd1) >= {1'b0, cell_lim};
  assign vrem_dec = (vrem_r != 19'd0) ? vrem_r - 19'd1 : vrem_r;

  // Item decode and next state
  always_comb begin
    phase_nxt = phase_r;
    bbs_nxt   = bbs_r;
    exp_nxt   = exp_r;
    vrem_nxt  = vrem_r;
    pos_nxt   = pos_r;
    asm_nxt   = asm_r;
    cell_nxt  = cell_r;
    cum_nxt   = cum_r;
    finish    = 1'b0;
    fin_exp   = exp_r;

    rec         = '0;
    rec.base    = bbs_r;
    rec.cell_no = cell_r;

    case (phase_r)
      PH_BITMAP: begin
        rec.mask = stream_byte;
        exp_nxt  = exp_add;
        if (({1'b0, bbs_r} + 16'd1) >= bm_len) begin
          bbs_nxt = 15'd0;
          if (exp_add == 19'd0) begin
            finish  = 1'b1;
            fin_exp = exp_add;
          end else begin
            phase_nxt = PH_VALUES;
            vrem_nxt  = exp_add;
            pos_nxt   = 2'd0;
            asm_nxt   = 24'd0;
          end
        end else begin
          bbs_nxt = bbs_r + 15'd1;
        end
      end
      PH_VALUES: begin
        if (cfg.value_mode) begin
          rec.has_val = 1'b1;
          rec.val     = {24'd0, stream_byte};
          pos_nxt     = 2'd0;
          asm_nxt     = 24'd0;
        end else if (pos_r == 2'd3) begin
          rec.has_val = 1'b1;
          rec.val     = {stream_byte, asm_r};
          pos_nxt     = 2'd0;
          asm_nxt     = 24'd0;
        end else begin
          case (pos_r)
            2'd0:    asm_nxt = asm_r | {16'd0, stream_byte};
            2'd1:    asm_nxt = asm_r | {8'd0, stream_byte, 8'd0};
            default: asm_nxt = asm_r | {stream_byte, 16'd0};
          endcase
          pos_nxt = pos_r + 2'd1;
        end
        if (rec.has_val) begin
          vrem_nxt = vrem_dec;
          if (vrem_dec == 19'd0) finish = 1'b1;
        end
      end
      default: ;
    endcase

    // End of cell
    if (finish) begin
      rec.has_end = 1'b1;
      rec.total   = tot_sat;
      rec.done    = is_last;
      cum_nxt     = tot_sat;
      cell_nxt    = cell_r + 24'd1;
      exp_nxt     = 19'd0;
      vrem_nxt    = 19'd0;
      pos_nxt     = 2'd0;
      asm_nxt     = 24'd0;
      bbs_nxt     = 15'd0;
      phase_nxt   = is_last ? PH_DONE : PH_BITMAP;
    end
  end

  assign rec_any = (rec.mask != 8'd0) || rec.has_val || rec.has_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BITMAP;
      bbs_r   <= '0;
      exp_r   <= '0;
      vrem_r  <= '0;
      pos_r   <= '0;
      asm_r   <= '0;
      cell_r  <= '0;
      cum_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      bbs_r   <= bbs_nxt;
      exp_r   <= exp_nxt;
      vrem_r  <= vrem_nxt;
      pos_r   <= pos_nxt;
      asm_r   <= asm_nxt;
      cell_r  <= cell_nxt;
      cum_r   <= cum_nxt;
    end
  end

endmodule

### hdl/bsd_emitter.sv
module bsd_emitter
  import bsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  bsd_rec_t    rec,
  input  logic        rec_any,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [17:0] out_gene_index,
  output logic [31:0] out_value_bits,
  output logic [23:0] out_cell_number,
  output logic [31:0] out_running_total,
  output logic        out_last,
  output logic        out_done_res
);

  bsd_rec_t    pend_r, pend_nxt;
  logic        pend_v_r, pend_v_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [17:0] gene_r, gene_nxt;
  logic [31:0] val_r, val_nxt;
  logic [23:0] cell_r, cell_nxt;
  logic [31:0] tot_r, tot_nxt;
  logic        last_r, last_nxt;
  logic        done_r, done_nxt;

  logic        slot_free;
  logic        emit;
  logic        found;
  logic [2:0]  sel;
  logic [7:0]  mask_rest;
  logic        em_last;

  assign slot_free = !ov_r || out_ready;
  assign emit      = pend_v_r && slot_free;

  // First set bit from the MSB
  always_comb begin
    found = 1'b0;
    sel   = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (pend_r.mask[k] && !found) begin
        found = 1'b1;
        sel   = 3'(k);
      end
    end
    mask_rest      = pend_r.mask;
    mask_rest[sel] = 1'b0;
  end

  // Pick the next result of the pending item
  always_comb begin
    pend_nxt  = pend_r;
    kind_nxt  = kind_r;
    gene_nxt  = gene_r;
    val_nxt   = val_r;
    cell_nxt  = cell_r;
    tot_nxt   = tot_r;
    last_nxt  = last_r;
    done_nxt  = done_r;
    ov_nxt    = ov_r && !out_ready;
    em_last   = 1'b0;

    if (emit) begin
      ov_nxt   = 1'b1;
      cell_nxt = pend_r.cell_no;
      gene_nxt = 18'd0;
      val_nxt  = 32'd0;
      tot_nxt  = 32'd0;
      done_nxt = 1'b0;
      if (found) begin
        kind_nxt      = KIND_GENE;
        gene_nxt      = {pend_r.base, ~sel};
        pend_nxt.mask = mask_rest;
        em_last       = (mask_rest == 8'd0) && !pend_r.has_val && !pend_r.has_end;
      end else if (pend_r.has_val) begin
        kind_nxt         = KIND_VALUE;
        val_nxt          = pend_r.val;
        pend_nxt.has_val = 1'b0;
        em_last          = !pend_r.has_end;
      end else begin
        kind_nxt         = KIND_END;
        tot_nxt          = pend_r.total;
        done_nxt         = pend_r.done;
        pend_nxt.has_end = 1'b0;
        em_last          = 1'b1;
      end
      last_nxt = em_last;
    end

    pend_v_nxt = pend_v_r && !(emit && em_last);
    if (load) begin
      pend_nxt   = rec;
      pend_v_nxt = rec_any;
    end
  end

  assign free = !pend_v_r || (emit && em_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    kind_r <= kind_nxt;
    gene_r <= gene_nxt;
    val_r  <= val_nxt;
    cell_r <= cell_nxt;
    tot_r  <= tot_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  assign out_valid         = ov_r;
  assign out_kind          = kind_r;
  assign out_gene_index    = gene_r;
  assign out_value_bits    = val_r;
  assign out_cell_number   = cell_r;
  assign out_running_total = tot_r;
  assign out_last          = last_r;
  assign out_done_res      = done_r;

endmodule

### hdl/bitmap_sparse_column_deframer_core.sv
// An accepted byte lands in the pending-item register at the accept edge; its first
// result moves to the output register when that is empty or being taken. Throughput,
// while out_ready holds: one byte per cycle if each byte causes at most one result, one
// result per cycle at the output port; a byte with n results holds off the next byte.
// Reset (rst_n low, synchronous): stream state back to the start of cell 0, pending and
// output registers empty, registers to gene_count 1, value_mode 0, cell_count 1.
module bitmap_sparse_column_deframer_core
  import bsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [17:0] out_gene_index,
  output logic [31:0] out_value_bits,
  output logic [23:0] out_cell_number,
  output logic [31:0] out_running_total,
  output logic        out_last,
  output logic        out_done_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  bsd_cfg_t cfg_r, cfg_nxt;
  bsd_rec_t rec;
  logic     rec_any;
  logic     free;
  logic     take;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_GENE_COUNT: cfg_nxt.gene_count = cfg_data[18:0];
        CFG_VALUE_MODE: cfg_nxt.value_mode = cfg_data[0];
        CFG_CELL_COUNT: cfg_nxt.cell_count = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gene_count <= 19'd1;
      cfg_r.value_mode <= 1'b0;
      cfg_r.cell_count <= 24'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ready = free;
  assign take     = in_valid && free;

  bsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .stream_byte (in_stream_byte),
    .cfg         (cfg_r),
    .rec         (rec),
    .rec_any     (rec_any)
  );

  bsd_emitter u_emitter (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (take),
    .rec               (rec),
    .rec_any           (rec_any),
    .free              (free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_gene_index    (out_gene_index),
    .out_value_bits    (out_value_bits),
    .out_cell_number   (out_cell_number),
    .out_running_total (out_running_total),
    .out_last          (out_last),
    .out_done_res      (out_done_res)
  );

endmodule

### test/bitmap_sparse_column_deframer_core_test.sv
`timescale 1ns / 1ps

module bitmap_sparse_column_deframer_core_test;
  import bsd_pkg::*;

  // Index with no register behind it; a write there changes nothing
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS = 280;

  // Two genes (0 and 15) followed by two float values
  localparam logic [7:0] FLOAT_CELL [10] = '{8'h80, 8'h01, 8'h00, 8'h00, 8'h80, 8'h3F,
                                             8'h78, 8'h56, 8'h34, 8'h12};
  // Full bitmap byte, then eight tier values
  localparam logic [7:0] TIER_CELL [9] = '{8'hFF, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h55,
                                           8'hAA, 8'h7F, 8'hFE};

  typedef struct packed {
    logic [1:0]  kind;
    logic [17:0] gene;
    logic [31:0] value;
    logic [23:0] cell_no;
    logic [31:0] total;
    logic        last;
    logic        done;
  } deframe_result_t;

  // Tracks the stream parser and holds the results each accepted byte should produce
  class deframe_scoreboard;
    logic [18:0]     gene_reg;
    logic            tier_reg;
    logic [23:0]     cell_limit_reg;
    phase_t          phase;
    int unsigned     bytes_seen;
    int unsigned     expressed;
    int unsigned     values_left;
    int unsigned     byte_pos;
    logic [23:0]     assembly;
    logic [23:0]     cell_no;
    logic [31:0]     total;
    deframe_result_t expected_results[$];
    int unsigned     failures;

    function new();
      gene_reg = 19'd1;
      tier_reg = 1'b0;
      cell_limit_reg = 24'd1;
      phase = PH_BITMAP;
      bytes_seen = 0;
      expressed = 0;
      values_left = 0;
      byte_pos = 0;
      assembly = '0;
      cell_no = '0;
      total = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        CFG_GENE_COUNT: gene_reg = data[18:0];
        CFG_VALUE_MODE: tier_reg = data[0];
        CFG_CELL_COUNT: cell_limit_reg = data;
        default: ;
      endcase
    endfunction

    function bit at_cell_start();
      return phase == PH_BITMAP && bytes_seen == 0;
    endfunction

    function bit is_done();
      return phase == PH_DONE;
    endfunction

    // Zero genes reads as one, oversize counts clamp to the maximum
    function int unsigned bitmap_bytes();
      int unsigned g;
      g = gene_reg;
      if (g == 0) g = 1;
      if (g > MAX_GENES) g = MAX_GENES;
      return (g + 7) >> 3;
    endfunction

    function void emit(logic [1:0] kind, logic [17:0] gene, logic [31:0] value,
                       logic [31:0] run_total, logic done);
      deframe_result_t r;
      r.kind = kind;
      r.gene = gene;
      r.value = value;
      r.cell_no = cell_no;
      r.total = run_total;
      r.last = 1'b0;
      r.done = done;
      expected_results.push_back(r);
    endfunction

    // End of cell: saturating column-pointer total, then on to the next cell or done
    function void close_cell();
      logic [32:0] sum;
      logic [31:0] limit;
      logic        final_cell;
      sum = {1'b0, total} + 33'(expressed);
      total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      limit = (cell_limit_reg == 24'd0) ? 32'd1 : {8'd0, cell_limit_reg};
      final_cell = ({8'd0, cell_no} + 32'd1) >= limit;
      emit(KIND_END, '0, '0, total, final_cell);
      cell_no = cell_no + 24'd1;
      expressed = 0;
      values_left = 0;
      byte_pos = 0;
      assembly = '0;
      bytes_seen = 0;
      phase = final_cell ? PH_DONE : PH_BITMAP;
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned j;
      int          first;
      logic [31:0] v;
      bit          have;
      first = expected_results.size();
      have = 1'b0;
      v = '0;
      if (phase == PH_BITMAP) begin
        // MSB first: bit i from the top of byte j is gene 8j+i
        j = bytes_seen;
        for (int i = 0; i < 8; i++) begin
          if (b[7 - i]) begin
            emit(KIND_GENE, 18'(8 * j + i), '0, '0, 1'b0);
            expressed++;
          end
        end
        if (j + 1 >= bitmap_bytes()) begin
          bytes_seen = 0;
          if (expressed == 0) begin
            close_cell();
          end else begin
            phase = PH_VALUES;
            values_left = expressed;
            byte_pos = 0;
            assembly = '0;
          end
        end else begin
          bytes_seen = j + 1;
        end
      end else if (phase == PH_VALUES) begin
        // Tier bytes stand alone; floats gather four bytes, low byte first
        if (tier_reg) begin
          v = {24'd0, b};
          have = 1'b1;
          byte_pos = 0;
          assembly = '0;
        end else if (byte_pos >= 3) begin
          v = {b, assembly};
          have = 1'b1;
          byte_pos = 0;
          assembly = '0;
        end else begin
          assembly = assembly | (24'(b) << (8 * byte_pos));
          byte_pos++;
        end
        if (have) begin
          emit(KIND_VALUE, '0, v, '0, 1'b0);
          if (values_left > 0) values_left--;
          if (values_left == 0) close_cell();
        end
      end
      // Bytes after the last cell produce nothing
      if (expected_results.size() > first)
        expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    function void match_result(deframe_result_t got);
      deframe_result_t want;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: kind %0d gene %0d value %h cell %0d",
                   got.kind, got.gene, got.value, got.cell_no,
                   " total %0d last %b done %b", got.total, got.last, got.done);
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.gene !== want.gene || got.value !== want.value ||
          got.cell_no !== want.cell_no || got.total !== want.total ||
          got.last !== want.last || got.done !== want.done) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch (expected/actual): kind %0d/%0d gene %0d/%0d value %h/%h",
                   want.kind, got.kind, want.gene, got.gene, want.value, got.value);
          $display("  cell %0d/%0d total %0d/%0d last %b/%b done %b/%b",
                   want.cell_no, got.cell_no, want.total, got.total,
                   want.last, got.last, want.done, got.done);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [17:0] out_gene_index;
  logic [31:0] out_value_bits;
  logic [23:0] out_cell_number;
  logic [31:0] out_running_total;
  logic        out_last;
  logic        out_done_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_GENE_COUNT;
  logic [23:0] cfg_data = 24'd0;

  deframe_scoreboard sb;
  deframe_result_t   seen_result;
  int                burst_left = 0;
  int                quiet_cycles = 0;
  logic [15:0]       rx_cycle = '0;

  bitmap_sparse_column_deframer_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_gene_index    (out_gene_index),
    .out_value_bits    (out_value_bits),
    .out_cell_number   (out_cell_number),
    .out_running_total (out_running_total),
    .out_last          (out_last),
    .out_done_res      (out_done_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  // Receiver: cycles through always-ready, light, periodic and heavy stalling
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    case (rx_cycle[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(3, 0) != 0);
      2'd2: out_ready <= (rx_cycle % 3 == 0);
      default: out_ready <= 1'($urandom_range(1, 0));
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result.kind = out_kind;
      seen_result.gene = out_gene_index;
      seen_result.value = out_value_bits;
      seen_result.cell_no = out_cell_number;
      seen_result.total = out_running_total;
      seen_result.last = out_last;
      seen_result.done = out_done_res;
      sb.match_result(seen_result);
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Random bytes, with empty, full and single-bit bitmap bytes common
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7, 0))
      0, 1: return 8'h00;
      2: return 8'hFF;
      3: return 8'h80 >> $urandom_range(7, 0);
      default: return 8'($urandom);
    endcase
  endfunction

  // Send one item; the sender runs in bursts with gaps between them
  task automatic push_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat ($urandom_range(10, 0)) @(negedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(120, 40) : $urandom_range(16, 1);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_byte(b);
    burst_left--;
  endtask

  // Stop sending and let every expected result drain out
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  initial begin
    int rand_sent;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    write_reg(CFG_CELL_COUNT, 24'hFFFFFF);
    write_reg(CFG_GENE_COUNT, 24'd16);
    write_reg(CFG_VALUE_MODE, 24'd0);

    // Float cell, then an empty cell
    foreach (FLOAT_CELL[i]) push_byte(FLOAT_CELL[i]);
    push_byte(8'h00);
    push_byte(8'h00);

    // Zero genes reads as one bitmap byte; tier values
    drain();
    write_reg(CFG_UNUSED, 24'($urandom));
    write_reg(CFG_VALUE_MODE, 24'd1);
    write_reg(CFG_GENE_COUNT, 24'd0);
    foreach (TIER_CELL[i]) push_byte(TIER_CELL[i]);

    // Bitmap shrunk under its read position, then tier mode mid float
    drain();
    write_reg(CFG_VALUE_MODE, 24'd0);
    write_reg(CFG_GENE_COUNT, 24'd24);
    push_byte(8'h40);
    drain();
    write_reg(CFG_GENE_COUNT, 24'd8);
    push_byte(8'h20);
    push_byte(8'h11);
    push_byte(8'h22);
    drain();
    write_reg(CFG_VALUE_MODE, 24'd1);
    push_byte(8'h33);
    push_byte(8'h44);

    // Random cells; some settings change mid cell
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(7, 0))
        0: write_reg(CFG_GENE_COUNT, 24'd0);
        1: write_reg(CFG_GENE_COUNT, 24'd1);
        2: write_reg(CFG_GENE_COUNT, 24'd8);
        3: write_reg(CFG_GENE_COUNT, 24'd9);
        4: write_reg(CFG_GENE_COUNT, 24'($urandom_range(24, 2)));
        5: write_reg(CFG_GENE_COUNT, 24'($urandom_range(64, 25)));
        6: write_reg(CFG_GENE_COUNT, 24'd16);
        default: write_reg(CFG_GENE_COUNT, 24'($urandom_range(16, 1)));
      endcase
      if ($urandom_range(1, 0) != 0)
        write_reg(CFG_VALUE_MODE, {23'($urandom), 1'($urandom_range(1, 0))});
      if ($urandom_range(9, 0) == 0)
        write_reg(CFG_CELL_COUNT, 24'($urandom_range(24'hFFFFFF, 24'h001000)));
      repeat ($urandom_range(40, 8)) begin
        push_byte(pick_byte());
        rand_sent++;
      end
      if ($urandom_range(3, 0) != 0) begin
        while (!sb.at_cell_start()) begin
          push_byte(pick_byte());
          rand_sent++;
        end
      end
    end

    // Cell count zero acts as one: the current cell is the last
    drain();
    write_reg(CFG_CELL_COUNT, 24'd0);
    while (!sb.is_done()) push_byte(pick_byte());
    // Ignored once done
    repeat (3) push_byte(8'($urandom));

    @(negedge clk) in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
